[hdl/hjx_pkg.sv]
// shared types, constants and helpers for the head jump crossfade mixer
package hjx_pkg;

    localparam int NUM_HEADS_DEF   = 4;
    localparam int LOOP_LENGTH_DEF = 65536;

    localparam logic [15:0] FADE_LEN_RST = 16'd512;
    localparam logic [16:0] Q15_ONE      = 17'd32768;
    localparam logic [16:0] HALF_SAMPLE  = 17'h08000;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1
    } t_alu_op;

    typedef logic [3:0][15:0] t_amts;

    typedef struct packed {
        logic        func;
        logic [1:0]  head_index;
        logic [15:0] read_amt;
        logic [15:0] write_amt;
        logic [15:0] erase_amt;
        logic [15:0] feedback_amount;
        logic [15:0] head_position;
        logic        reversed;
        logic        teleported;
        logic [31:0] jump_old_position;
        logic [23:0] jump_prev_speed;
        logic        jump_old_forward;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_head_index;
        logic        is_fading_copy;
        logic [15:0] weight;
        logic [15:0] out_read;
        logic [15:0] out_write;
        logic [15:0] out_erase;
        logic [15:0] out_feedback;
        logic [15:0] out_position;
        logic        last;
    } t_out_item;

    function automatic logic [15:0] sat_q15(input logic [15:0] v);
        return (v > 16'd32768) ? 16'd32768 : v;
    endfunction

endpackage

[hdl/hjx_if.sv]
// valid/ready channel interfaces for input items and result items
interface hjx_in_if;
    logic               valid;
    logic               ready;
    hjx_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hjx_out_if;
    logic               valid;
    logic               ready;
    hjx_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/hjx_alu.sv]
// shared add/subtract-compare and 17x17 multiply unit
module hjx_alu #(
    parameter int AW = 33
) (
    input  hjx_pkg::t_alu_op i_op,
    input  logic [AW-1:0]    i_a,
    input  logic [AW-1:0]    i_b,
    input  logic [16:0]      i_ma,
    input  logic [16:0]      i_mb,
    output logic [AW-1:0]    o_res,
    output logic             o_ge,
    output logic [33:0]      o_prod
);
    always_comb begin
        unique case (i_op)
            hjx_pkg::ALU_ADD: o_res = i_a + i_b;
            hjx_pkg::ALU_SUB: o_res = i_a - i_b;
            default:          o_res = i_a - i_b;
        endcase
    end

    assign o_ge   = (i_a >= i_b);
    assign o_prod = 34'(i_ma) * 34'(i_mb);
endmodule

[hdl/head_jump_crossfade_mixer_core.sv]
// top level: sequencer, per-head fade state and result register
// flow: a plain or reset item runs prep, multiply and emit; a fading tick also runs the old
//   weight compare, rounding and advance, the 15 step division when the old weight needs it,
//   and the position and speed reduction on a tick that starts a fade
// throughput: one item at a time; a fade may give a second result after the first transfer
// reset: synchronous active low; clears fades, seen flags, sequencer, fade_length to 512
module head_jump_crossfade_mixer_core #(
    parameter int NUM_HEADS   = hjx_pkg::NUM_HEADS_DEF,
    parameter int LOOP_LENGTH = hjx_pkg::LOOP_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    hjx_in_if.sink      i_in,
    hjx_out_if.source   o_out
);
    // widths: position hi part mod LOOP_LENGTH, LW.16 position, alu word
    localparam int LW    = (LOOP_LENGTH > 1) ? $clog2(LOOP_LENGTH) : 1;
    localparam int POS_W = LW + 16;
    localparam int AW    = POS_W + 1;
    localparam int HW    = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
    localparam logic [AW-1:0] MOD_L = AW'(LOOP_LENGTH);
    localparam logic [AW-1:0] MOD_M = MOD_L << 16;
    // reciprocal of the loop length for the whole-sample reduction; a 16 bit value
    // is always below a loop length of 65536 or more
    localparam logic [16:0] MOD_LM  = (LOOP_LENGTH < 65536) ? 17'(LOOP_LENGTH) : 17'd0;
    localparam logic [16:0] MOD_RCP = (LOOP_LENGTH < 65536) ? 17'(65536 / LOOP_LENGTH)
                                                            : 17'd0;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PREP = 10'b0000000010,
        S_MOD  = 10'b0000000100,
        S_WCMP = 10'b0000001000,
        S_WDIV = 10'b0000010000,
        S_RND  = 10'b0000100000,
        S_ADV1 = 10'b0001000000,
        S_ADV2 = 10'b0010000000,
        S_MUL  = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;

    // per-head state
    logic [NUM_HEADS-1:0] r_fact, r_seen;
    logic [15:0]           r_frem [NUM_HEADS];
    logic [POS_W-1:0]      r_fpos [NUM_HEADS];
    logic [POS_W-1:0]      r_fspd [NUM_HEADS];
    logic                  r_ffwd [NUM_HEADS];
    hjx_pkg::t_amts        r_famt [NUM_HEADS];
    hjx_pkg::t_amts        r_prev [NUM_HEADS];
    logic [15:0]           r_flen;

    // working registers for the item in flight
    hjx_pkg::t_in_item  r_in;
    hjx_pkg::t_amts     r_cur;
    logic [AW-1:0]      r_acc;
    logic [14:0]        r_q;
    logic [15:0]        r_wold;
    logic [15:0]        r_p;
    logic               r_bor;
    logic               r_copy;
    logic [15:0]        r_w;
    logic               r_last;
    hjx_pkg::t_out_item r_out;

    logic [HW-1:0]    w_h;
    logic [15:0]      w_len, w_wnew;
    hjx_pkg::t_amts   w_prev_eff;
    logic             w_start, w_accept, w_out_done;
    hjx_pkg::t_alu_op w_op;
    logic [AW-1:0]    w_a, w_b, w_res, w_acc_nxt;
    logic             w_ge;
    logic [16:0]      w_ma, w_mb, w_amt, w_q;
    logic [33:0]      w_prod;
    logic [AW-1:0]    w_rnd_hi;
    logic [POS_W-1:0] w_pos_nxt;
    logic [15:0]      w_mod_x;

    assign w_h    = HW'(r_in.head_index);
    assign w_len  = (r_flen == 16'd0) ? 16'd1 : r_flen;
    assign w_wnew = 16'(hjx_pkg::Q15_ONE - 17'(r_wold));
    assign w_prev_eff = r_seen[w_h] ? r_prev[w_h] : r_cur;

    // fade starts on this head's own jump while audible before and after
    assign w_start = (r_in.reversed | r_in.teleported)
                   & ((r_cur[0] != 16'd0) | (r_cur[1] != 16'd0))
                   & ((w_prev_eff[0] != 16'd0) | (w_prev_eff[1] != 16'd0));

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = (r_state == S_EMIT);
    assign o_out.payload = r_out;
    assign w_accept      = i_in.valid & i_in.ready;
    assign w_out_done    = o_out.valid & o_out.ready;

    // whole-sample part under reduction: position first, then speed
    assign w_mod_x = r_cnt[2] ? {8'd0, r_in.jump_prev_speed[23:16]}
                              : r_in.jump_old_position[31:16];

    // operand selection for the shared unit
    always_comb begin
        w_op = hjx_pkg::ALU_SUB;
        w_a  = r_acc;
        w_b  = MOD_L;
        unique case (r_state)
            S_MOD: begin
                // step 2: value minus estimate times length, step 3: final correction
                w_a = (r_cnt[1:0] == 2'd3) ? r_acc : AW'(w_mod_x);
                w_b = (r_cnt[1:0] == 2'd3) ? MOD_L : r_acc;
            end
            S_WCMP: begin
                w_a = AW'(r_frem[w_h]);
                w_b = AW'(w_len);
            end
            S_WDIV: begin
                w_a = {r_acc[AW-2:0], 1'b0};
                w_b = AW'(w_len);
            end
            S_RND: begin
                w_op = hjx_pkg::ALU_ADD;
                w_a  = AW'(r_fpos[w_h]);
                w_b  = AW'(hjx_pkg::HALF_SAMPLE);
            end
            S_ADV1: begin
                w_op = r_ffwd[w_h] ? hjx_pkg::ALU_ADD : hjx_pkg::ALU_SUB;
                w_a  = AW'(r_fpos[w_h]);
                w_b  = AW'(r_fspd[w_h]);
            end
            S_ADV2: begin
                w_op = r_ffwd[w_h] ? hjx_pkg::ALU_SUB : hjx_pkg::ALU_ADD;
                w_a  = r_acc;
                w_b  = MOD_M;
            end
            default: begin
                w_op = hjx_pkg::ALU_SUB;
            end
        endcase
    end

    // multiply operands: amount times weight, erase works on its complement;
    // during the reduction the quotient estimate and its product with the length
    always_comb begin
        w_amt = 17'(r_copy ? r_famt[w_h][r_cnt[1:0]] : r_cur[r_cnt[1:0]]);
        w_ma  = (r_cnt[1:0] == 2'd2) ? (hjx_pkg::Q15_ONE - w_amt) : w_amt;
        w_mb  = 17'(r_w);
        if (r_state == S_MOD) begin
            if (r_cnt[0]) begin
                w_ma = r_acc[16:0];
                w_mb = MOD_LM;
            end else begin
                w_ma = 17'(w_mod_x);
                w_mb = MOD_RCP;
            end
        end
    end

    hjx_alu #(.AW(AW)) u_alu (
        .i_op   (w_op),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_ma   (w_ma),
        .i_mb   (w_mb),
        .o_res  (w_res),
        .o_ge   (w_ge),
        .o_prod (w_prod)
    );

    assign w_acc_nxt = w_ge ? w_res : w_a;
    assign w_q       = 17'(w_prod[30:15]);
    // rounded whole sample equals the loop length only at the wrap point
    assign w_rnd_hi  = w_res >> 16;
    assign w_pos_nxt = r_ffwd[w_h] ? POS_W'(w_ge ? w_res : r_acc)
                                   : POS_W'(r_bor ? w_res : r_acc);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 4'd1;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = 4'd0;
                if (w_accept && (int'(i_in.payload.head_index) < NUM_HEADS)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_cnt = 4'd0;
                if (r_in.func)                   n_state = S_MUL;
                else if (w_start)                n_state = S_MOD;
                else if (r_fact[w_h])            n_state = S_WCMP;
                else                             n_state = S_MUL;
            end
            S_MOD: begin
                if (r_cnt == 4'd7) n_state = S_WCMP;
            end
            S_WCMP: begin
                n_cnt   = 4'd0;
                n_state = w_ge ? S_RND : S_WDIV;
            end
            S_WDIV: begin
                if (r_cnt == 4'd14) n_state = S_RND;
            end
            S_RND:  n_state = S_ADV1;
            S_ADV1: n_state = S_ADV2;
            S_ADV2: begin
                n_cnt   = 4'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == 4'd3) n_state = S_EMIT;
            end
            S_EMIT: begin
                n_cnt = 4'd0;
                if (w_out_done) begin
                    n_state = (r_copy && (w_wnew != 16'd0)) ? S_MUL : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and per-head flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 4'd0;
            r_fact  <= '0;
            r_seen  <= '0;
            r_flen  <= hjx_pkg::FADE_LEN_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) r_flen <= i_cfg_wr_data;
            if (r_state == S_PREP) begin
                r_seen[w_h] <= 1'b1;
                if (r_in.func)    r_fact <= '0;
                else if (w_start) r_fact[w_h] <= 1'b1;
            end
            // fade ends when the countdown hits zero
            if ((r_state == S_ADV2) && (r_frem[w_h] == 16'd1)) r_fact[w_h] <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_in     <= i_in.payload;
                r_cur[0] <= hjx_pkg::sat_q15(i_in.payload.read_amt);
                r_cur[1] <= hjx_pkg::sat_q15(i_in.payload.write_amt);
                r_cur[2] <= hjx_pkg::sat_q15(i_in.payload.erase_amt);
                r_cur[3] <= hjx_pkg::sat_q15(i_in.payload.feedback_amount);
            end
            S_PREP: begin
                r_prev[w_h] <= r_cur;
                r_copy      <= 1'b0;
                r_w         <= 16'(hjx_pkg::Q15_ONE);
                r_last      <= 1'b1;
                if (!r_in.func && w_start) begin
                    // snapshot of the pre-jump head
                    r_frem[w_h] <= w_len;
                    r_ffwd[w_h] <= r_in.jump_old_forward;
                    r_famt[w_h] <= w_prev_eff;
                end
            end
            S_MOD: begin
                // estimate is at most one below the true quotient
                case (r_cnt[1:0])
                    2'd0:    r_acc <= AW'(w_prod[32:16]);
                    2'd1:    r_acc <= AW'(w_prod);
                    2'd2:    r_acc <= w_res;
                    default: begin
                        if (r_cnt[2]) begin
                            r_fspd[w_h] <= {w_acc_nxt[LW-1:0], r_in.jump_prev_speed[15:0]};
                        end else begin
                            r_fpos[w_h] <= {w_acc_nxt[LW-1:0], r_in.jump_old_position[15:0]};
                        end
                    end
                endcase
            end
            S_WCMP: begin
                r_wold <= 16'(hjx_pkg::Q15_ONE);
                r_acc  <= AW'(r_frem[w_h]);
                r_q    <= '0;
            end
            S_WDIV: begin
                r_acc <= w_acc_nxt;
                r_q   <= {r_q[13:0], w_ge};
                if (r_cnt == 4'd14) r_wold <= {1'b0, r_q[13:0], w_ge};
            end
            S_RND: begin
                r_p <= (w_rnd_hi == MOD_L) ? 16'd0 : 16'(w_rnd_hi);
            end
            S_ADV1: begin
                r_acc <= w_res;
                r_bor <= ~w_ge;
            end
            S_ADV2: begin
                r_fpos[w_h] <= w_pos_nxt;
                r_frem[w_h] <= r_frem[w_h] - 16'd1;
                if (r_wold != 16'd0) begin
                    r_copy <= 1'b1;
                    r_w    <= r_wold;
                    r_last <= (w_wnew == 16'd0);
                end else begin
                    r_copy <= 1'b0;
                    r_w    <= w_wnew;
                    r_last <= 1'b1;
                end
            end
            S_MUL: begin
                case (r_cnt[1:0])
                    2'd0:    r_out.out_read     <= w_q[15:0];
                    2'd1:    r_out.out_write    <= w_q[15:0];
                    2'd2:    r_out.out_erase    <= 16'(hjx_pkg::Q15_ONE - w_q);
                    default: r_out.out_feedback <= w_q[15:0];
                endcase
                r_out.out_head_index <= r_in.head_index;
                r_out.is_fading_copy <= r_copy;
                r_out.weight         <= r_w;
                r_out.out_position   <= r_copy ? r_p : r_in.head_position;
                r_out.last           <= r_last;
            end
            S_EMIT: begin
                // second transfer of a fade: current head at the complement
                if (w_out_done) begin
                    r_copy <= 1'b0;
                    r_w    <= w_wnew;
                    r_last <= 1'b1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // no new item while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    // the final transfer of an item returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.payload.last) |=> i_in.ready)
        else $error("block not idle after last transfer");

    // zero weight results are never shown
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.payload.weight != 16'd0))
        else $error("zero weight result");

endmodule

[tb/head_jump_crossfade_mixer_core_tb.sv]
// testbench for the head jump crossfade mixer: directed and random head ticks against a predictor
`timescale 1ns / 100ps

module head_jump_crossfade_mixer_core_tb;

    localparam int NHEAD    = 4;
    localparam int LOOP_LEN = 65536;
    localparam logic [47:0] POS_MOD = 48'(LOOP_LEN) << 16;
    localparam int STALL_LIMIT = 20000;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    hjx_in_if  in_ch ();
    hjx_out_if out_ch ();

    head_jump_crossfade_mixer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch.sink),
        .o_out         (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // predictor state, one entry per head
    logic [15:0]      len_reg;
    logic             fading [NHEAD];
    logic [15:0]      remain [NHEAD];
    logic [47:0]      old_pos [NHEAD];
    logic [23:0]      prior_spd [NHEAD];
    logic             old_fwd [NHEAD];
    logic [3:0][15:0] old_amts [NHEAD];
    logic [3:0][15:0] prev_amts [NHEAD];
    logic             seen [NHEAD];

    hjx_pkg::t_out_item expected_contribs [$];
    int  err_count = 0;
    int  idle_cycles = 0;
    bit  rx_stall_on = 1'b1;

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
    end

    function automatic hjx_pkg::t_out_item scale_contrib(logic [1:0] h, logic copy,
                                                         logic [16:0] w,
                                                         logic [3:0][15:0] am,
                                                         logic [15:0] pos);
        hjx_pkg::t_out_item r;
        logic [33:0] t;
        r.out_head_index = h;
        r.is_fading_copy = copy;
        r.weight = w[15:0];
        t = am[0] * w; r.out_read = 16'(t >> 15);
        t = am[1] * w; r.out_write = 16'(t >> 15);
        t = (17'd32768 - am[2]) * w; r.out_erase = 16'(17'd32768 - 17'(t >> 15));
        t = am[3] * w; r.out_feedback = 16'(t >> 15);
        r.out_position = pos;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_contribs(input hjx_pkg::t_in_item it);
        logic [3:0][15:0] cur;
        logic [1:0]  h;
        logic [16:0] len, w_old, w_new;
        logic [47:0] q, sp;
        hjx_pkg::t_out_item r;
        h = it.head_index;
        len = (len_reg == 0) ? 17'd1 : {1'b0, len_reg};
        cur[0] = hjx_pkg::sat_q15(it.read_amt);
        cur[1] = hjx_pkg::sat_q15(it.write_amt);
        cur[2] = hjx_pkg::sat_q15(it.erase_amt);
        cur[3] = hjx_pkg::sat_q15(it.feedback_amount);
        if (!seen[h]) begin
            prev_amts[h] = cur;
            seen[h] = 1'b1;
        end
        if (it.func == FUNC_RESET) begin
            for (int k = 0; k < NHEAD; k++) begin
                fading[k] = 1'b0;
                remain[k] = '0;
            end
            prev_amts[h] = cur;
            r = scale_contrib(h, 1'b0, 17'd32768, cur, it.head_position);
            r.last = 1'b1;
            expected_contribs.push_back(r);
            return;
        end
        if ((it.reversed || it.teleported) && (cur[0] > 0 || cur[1] > 0) &&
            (prev_amts[h][0] > 0 || prev_amts[h][1] > 0)) begin
            fading[h]    = 1'b1;
            remain[h]    = len[15:0];
            old_pos[h]   = {16'd0, it.jump_old_position} % POS_MOD;
            prior_spd[h] = it.jump_prev_speed;
            old_fwd[h]   = it.jump_old_forward;
            old_amts[h]  = prev_amts[h];
        end
        if (fading[h]) begin
            q = ({32'd0, remain[h]} << 15) / len;
            w_old = (q > 32768) ? 17'd32768 : q[16:0];
            w_new = 17'd32768 - w_old;
            if (w_old > 0) begin
                q = ((old_pos[h] + 48'h8000) >> 16) % LOOP_LEN;
                expected_contribs.push_back(scale_contrib(h, 1'b1, w_old, old_amts[h],
                                                          q[15:0]));
            end
            if (w_new > 0) begin
                expected_contribs.push_back(scale_contrib(h, 1'b0, w_new, cur,
                                                          it.head_position));
            end
            sp = {24'd0, prior_spd[h]} % POS_MOD;
            if (old_fwd[h]) old_pos[h] = (old_pos[h] + sp) % POS_MOD;
            else old_pos[h] = (old_pos[h] + POS_MOD - sp) % POS_MOD;
            remain[h] = remain[h] - 1'b1;
            if (remain[h] == 0) fading[h] = 1'b0;
        end else begin
            expected_contribs.push_back(scale_contrib(h, 1'b0, 17'd32768, cur,
                                                      it.head_position));
        end
        prev_amts[h] = cur;
        // flag the final contribution of this tick
        r = expected_contribs.pop_back();
        r.last = 1'b1;
        expected_contribs.push_back(r);
    endtask

    // result checker: compare each transfer against the oldest expectation
    always @(posedge i_clk) begin
        hjx_pkg::t_out_item got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (expected_contribs.size() == 0) begin
                $error("unexpected result transfer %p", got);
                err_count++;
            end else begin
                want = expected_contribs.pop_front();
                if (got.out_head_index !== want.out_head_index) begin
                    $error("out_head_index exp %0d got %0d", want.out_head_index,
                           got.out_head_index); err_count++; end
                if (got.is_fading_copy !== want.is_fading_copy) begin
                    $error("is_fading_copy exp %0d got %0d", want.is_fading_copy,
                           got.is_fading_copy); err_count++; end
                if (got.weight !== want.weight) begin
                    $error("weight exp %0d got %0d", want.weight, got.weight);
                    err_count++; end
                if (got.out_read !== want.out_read) begin
                    $error("out_read exp %0d got %0d", want.out_read, got.out_read);
                    err_count++; end
                if (got.out_write !== want.out_write) begin
                    $error("out_write exp %0d got %0d", want.out_write, got.out_write);
                    err_count++; end
                if (got.out_erase !== want.out_erase) begin
                    $error("out_erase exp %0d got %0d", want.out_erase, got.out_erase);
                    err_count++; end
                if (got.out_feedback !== want.out_feedback) begin
                    $error("out_feedback exp %0d got %0d", want.out_feedback,
                           got.out_feedback); err_count++; end
                if (got.out_position !== want.out_position) begin
                    $error("out_position exp %0d got %0d", want.out_position,
                           got.out_position); err_count++; end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last);
                    err_count++; end
            end
        end
    end

    // receiver stall pattern, switched between a random pattern and always ready
    always @(negedge i_clk) begin
        if (rx_stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
        else out_ch.ready <= 1'b1;
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("head_jump_crossfade_mixer_core_tb: done, errors");
            $finish;
        end
    end

    int burst_left = 0;

    // one input transfer; sender idles between bursts of random length
    task automatic send_tick(input hjx_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_contribs(it);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_contribs.size() != 0) @(negedge i_clk);
        // every tick produces a result, but let the sequencer settle anyway
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_fade_length(input logic [15:0] v);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        len_reg = v;
    endtask

    function automatic logic [15:0] rand_amount();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic hjx_pkg::t_in_item rand_tick(input bit jumpy);
        hjx_pkg::t_in_item it;
        it.func            = ($urandom_range(0, 40) == 0) ? FUNC_RESET : FUNC_TICK;
        it.head_index      = 2'($urandom);
        it.read_amt        = rand_amount();
        it.write_amt       = rand_amount();
        it.erase_amt       = rand_amount();
        it.feedback_amount = rand_amount();
        it.head_position   = 16'($urandom);
        it.reversed        = jumpy ? ($urandom_range(0, 5) == 0) : 1'b0;
        it.teleported      = jumpy ? ($urandom_range(0, 5) == 0) : 1'b0;
        it.jump_old_position = $urandom;
        it.jump_prev_speed = 24'($urandom);
        it.jump_old_forward = 1'($urandom);
        return it;
    endfunction

    task automatic test_directed();
        hjx_pkg::t_in_item it;
        // unseen heads at extremes, including amounts above one
        for (int h = 0; h < NHEAD; h++) begin
            it = '0;
            it.head_index = 2'(h);
            it.read_amt = (h == 0) ? 16'hFFFF : 16'd32768;
            it.write_amt = (h == 1) ? 16'd0 : 16'd32769;
            it.erase_amt = (h == 2) ? 16'hFFFF : 16'd0;
            it.feedback_amount = 16'd32768;
            it.head_position = (h == 3) ? 16'hFFFF : 16'd0;
            send_tick(it);
        end
        // jump that starts a fade, then ticks, then a jump while fading
        it = '1;
        it.func = FUNC_TICK;
        it.head_index = 2'd0;
        it.read_amt = 16'd20000;
        it.jump_prev_speed = 24'hFFFFFF;
        it.jump_old_position = 32'hFFFF_FFFF;
        send_tick(it);
        it.reversed = 1'b0; it.teleported = 1'b0;
        repeat (3) send_tick(it);
        it.teleported = 1'b1;
        it.jump_old_forward = 1'b0;
        it.jump_old_position = 32'h0000_7FFF;
        send_tick(it);
        it.teleported = 1'b0;
        send_tick(it);
        // jump with a silent head starts no fade
        it.head_index = 2'd1; it.read_amt = 0; it.write_amt = 0; it.reversed = 1'b1;
        send_tick(it);
        // reset item clears all fades
        it.func = FUNC_RESET; it.head_index = 2'd0;
        send_tick(it);
    endtask

    task automatic test_fade_lengths();
        hjx_pkg::t_in_item it;
        logic [15:0] lens [4] = '{16'd1, 16'd0, 16'd3, 16'd65535};
        foreach (lens[i]) begin
            set_fade_length(lens[i]);
            it = rand_tick(1'b0);
            it.func = FUNC_TICK; it.head_index = 2'd2;
            it.read_amt = 16'd1000; it.reversed = 1'b1;
            send_tick(it);
            it.reversed = 1'b0;
            repeat (4) send_tick(it);
        end
        // change length in the middle of a long fade
        set_fade_length(16'd2);
        repeat (3) send_tick(it);
    endtask

    task automatic test_random();
        hjx_pkg::t_in_item it;
        for (int n = 0; n < 500; n++) begin
            if (n == 150) set_fade_length(16'($urandom_range(1, 8)));
            if (n == 250) begin
                rx_stall_on = 1'b0;
                set_fade_length(16'($urandom_range(1, 40)));
            end
            if (n == 350) begin
                rx_stall_on = 1'b1;
                drain_results();
            end
            it = rand_tick(1'b1);
            // mostly audible heads so that fades get started
            if ($urandom_range(0, 3) != 0) it.read_amt = 16'($urandom_range(1, 32768));
            send_tick(it);
        end
        set_fade_length(hjx_pkg::FADE_LEN_RST);
        repeat (20) send_tick(rand_tick(1'b1));
    endtask

    initial begin
        len_reg = hjx_pkg::FADE_LEN_RST;
        for (int k = 0; k < NHEAD; k++) begin
            fading[k] = 1'b0; remain[k] = '0; seen[k] = 1'b0; prev_amts[k] = '0;
            old_pos[k] = '0; prior_spd[k] = '0; old_fwd[k] = 1'b0; old_amts[k] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_fade_lengths();
        test_random();
        drain_results();
        if (err_count == 0 && expected_contribs.size() == 0)
            $display("head_jump_crossfade_mixer_core_tb: done, clean");
        else
            $display("head_jump_crossfade_mixer_core_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/hjx_pkg.sv
hdl/hjx_if.sv
hdl/hjx_alu.sv
hdl/head_jump_crossfade_mixer_core.sv
tb/head_jump_crossfade_mixer_core_tb.sv
